// ----- hw/rtl/dct_pkg.sv -----
// Shared types and constants for the dyadic count tree.
package dct_pkg;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 17;
    localparam int COUNT_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // write zero at the clear address and advance it
        logic load;      // take the input beat and start a walk
        logic read;      // read the right child of the current node
        logic modify;    // update counter or sum, descend one level
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // clear pass writes its last entry this cycle
        logic skip;        // incoming beat needs no walk
        logic walk_end;    // this modify step is the last of the walk
        logic out_busy;    // output register holds a beat that is not taken
    } t_sts;

endpackage

// ----- hw/rtl/dct_ctrl.sv -----
// Controller state machine for the dyadic count tree.
module dct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dct_pkg::t_sts i_sts,
    output dct_pkg::t_cmd o_cmd
);

    dct_pkg::t_state r_state;
    dct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dct_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dct_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = dct_pkg::ST_IDLE;
                end
            end
            dct_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_sts.skip ? dct_pkg::ST_DONE : dct_pkg::ST_READ;
                end
            end
            dct_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state = dct_pkg::ST_MODIFY;
            end
            dct_pkg::ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state = i_sts.walk_end ? dct_pkg::ST_DONE : dct_pkg::ST_READ;
            end
            dct_pkg::ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = dct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/dct_datapath.sv -----
// Counter memory, walk registers and output register of the dyadic count tree.
module dct_datapath #(
    parameter int DEPTH      = 10,
    parameter int RANGE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dct_pkg::t_cmd                 i_cmd,
    output dct_pkg::t_sts                 o_sts,
    input  logic [dct_pkg::KIND_W-1:0]    i_kind,
    input  logic [dct_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dct_pkg::COUNT_W-1:0]   o_count,
    output logic [dct_pkg::VALUE_W-1:0]   o_range_bound
);

    localparam int NODE_W     = DEPTH + 1;
    localparam int TREE_NODES = (1 << (DEPTH + 1)) - 1;
    localparam int LVL_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW         = dct_pkg::VALUE_W;
    localparam int CW         = dct_pkg::COUNT_W;

    localparam logic [VW-1:0]     FULL_RANGE = VW'(1) << RANGE_BITS;
    localparam logic [VW-1:0]     MIN_VALUE  = FULL_RANGE >> DEPTH;
    localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(TREE_NODES - 1);
    localparam logic [LVL_W-1:0]  LAST_LVL   = LVL_W'(DEPTH - 1);

    logic [CW-1:0] mem [TREE_NODES];

    logic [dct_pkg::KIND_W-1:0] r_kind;
    logic [VW-1:0]              r_value;
    logic [NODE_W-1:0]          r_node;
    logic [VW-1:0]              r_mid;
    logic [VW-1:0]              r_step;
    logic [CW-1:0]              r_sum;
    logic [VW-1:0]              r_top;
    logic [LVL_W-1:0]           r_lvl;
    logic [CW-1:0]              r_rdata;
    logic [NODE_W-1:0]          r_clr_addr;
    logic                       r_out_valid;
    logic [CW-1:0]              r_out_count;
    logic [VW-1:0]              r_out_bound;

    logic [NODE_W-1:0] right_child;
    logic              go_right;
    logic              go_left;
    logic              hit;
    logic              is_ins;
    logic              is_del;
    logic              is_qry;
    logic              do_update;
    logic [CW-1:0]     upd_value;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [CW-1:0]     wr_data;

    always_comb begin
        right_child = {r_node[NODE_W-2:0], 1'b0} + NODE_W'(2);
        go_right    = r_value > r_mid;
        go_left     = r_value < r_mid;
        hit         = !go_right && !go_left;
        is_ins      = r_kind == dct_pkg::KIND_INSERT;
        is_del      = r_kind == dct_pkg::KIND_DELETE;
        is_qry      = r_kind == dct_pkg::KIND_QUERY;
        // Insert and delete touch the right child on a right turn or a midpoint hit.
        do_update   = (is_ins || is_del) && !go_left;
        if (is_ins) begin
            upd_value = r_rdata + CW'(1);
        end else if (r_rdata != '0) begin
            upd_value = r_rdata - CW'(1);
        end else begin
            upd_value = '0;
        end
        wr_en   = i_cmd.clear || (i_cmd.modify && do_update);
        wr_addr = i_cmd.clear ? r_clr_addr : right_child;
        wr_data = i_cmd.clear ? '0 : upd_value;
    end

    always_comb begin
        o_sts.clear_last = r_clr_addr == LAST_NODE;
        o_sts.skip       = (i_kind != dct_pkg::KIND_INSERT && i_kind != dct_pkg::KIND_DELETE
                            && i_kind != dct_pkg::KIND_QUERY)
                           || (i_kind != dct_pkg::KIND_QUERY && i_value < MIN_VALUE);
        o_sts.walk_end   = hit || (r_lvl == LAST_LVL);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.read) begin
            r_rdata <= mem[right_child];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + NODE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_node  <= '0;
            r_mid   <= FULL_RANGE >> 1;
            r_step  <= FULL_RANGE >> 2;
            r_sum   <= '0;
            r_top   <= FULL_RANGE;
            r_lvl   <= '0;
        end else if (i_cmd.modify) begin
            if (go_right) begin
                r_node <= right_child;
                r_mid  <= r_mid + r_step;
            end else if (go_left) begin
                r_node <= right_child - NODE_W'(1);
                r_mid  <= r_mid - r_step;
            end
            // A query collects the right sibling at a left turn and the right child on a hit.
            if (is_qry && !go_right) begin
                r_sum <= r_sum + r_rdata;
                r_top <= r_mid;
            end
            r_step <= r_step >> 1;
            r_lvl  <= r_lvl + LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_sum;
            r_out_bound <= r_top;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count       = r_out_count;
    assign o_range_bound = r_out_bound;

endmodule

// ----- hw/rtl/dyadic_count_tree.sv -----
// Dyadic count tree: a binary tree of 32-bit counters over 0..2^RANGE_BITS,
// updated by insert and delete beats and summed by query beats. Each beat
// walks the tree one level at a time with a read and, where an insert or
// delete updates a counter, a write of the single counter memory. After
// acceptance the walk alternates read and modify steps until the last
// level or an exact midpoint; then the done state loads the result
// register once the previous result has been taken and returns to idle.
// A beat that skips the walk (unused kind, or an insert or delete below
// 2^RANGE_BITS>>DEPTH) goes from idle straight to the done state. After
// reset the block clears its 2^(DEPTH+1)-1 counters one per cycle (2047 at
// DEPTH=10) before it takes its first beat. The output register lets the
// next beat enter while a finished result waits to be taken.
module dyadic_count_tree #(
    parameter int DEPTH      = 10,
    parameter int RANGE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [16:0] value, [23:17] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // [31:0] count, [48:32] range_bound, [55:49] zero
);

    dct_pkg::t_cmd cmd;
    dct_pkg::t_sts sts;

    logic [dct_pkg::COUNT_W-1:0] count;
    logic [dct_pkg::VALUE_W-1:0] range_bound;

    dct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dct_datapath #(
        .DEPTH      (DEPTH),
        .RANGE_BITS (RANGE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_s_axis_tuser),
        .i_value       (i_s_axis_tdata[dct_pkg::VALUE_W-1:0]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_count       (count),
        .o_range_bound (range_bound)
    );

    assign o_m_axis_tdata = {7'd0, range_bound, count};

endmodule
